/* rtl/core/mlfr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the MUSCL face
// reconstruction pipeline. No dependencies.
package mlfr_pkg;

    // Fixed-point format and epsilon
    localparam int FRAC_BITS = 16;
    localparam int EPS_LSB   = 1;

    // Magnitude width of limiter numerators and divisors
    localparam int MW      = 64 - FRAC_BITS;
    localparam int DW      = MW + 1;          // signed divider operand width
    localparam int NW      = MW + FRAC_BITS;  // scaled dividend width
    localparam int QB      = 33;              // quotient bits kept (32 + overflow)
    localparam int DIV_LAT = QB + 3;          // pipeline registers per divider
    localparam int CW      = 70;              // width used before clipping
    localparam int NSTG    = 12;              // stage registers outside dividers

    localparam logic signed [DW-1:0] ONE_W = DW'(64'd1 << FRAC_BITS);
    localparam logic signed [DW-1:0] EPS_W = DW'(EPS_LSB);
    localparam logic signed [CW-1:0] EPS_C = CW'(EPS_LSB);
    localparam logic signed [CW-1:0] CLIP_HI = {{(CW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [CW-1:0] CLIP_LO = {{(CW-31){1'b1}}, {31{1'b0}}};

    // Limiter codes
    typedef enum logic [2:0] {
        LIM_FIRST    = 3'd0,
        LIM_KOREN    = 3'd1,
        LIM_ALBADA   = 3'd2,
        LIM_SUPERBEE = 3'd3,
        LIM_MINMOD   = 3'd4,
        LIM_VANLEER  = 3'd5,
        LIM_CUSTOM   = 3'd6
    } lim_e;

    typedef struct packed {
        logic signed [31:0] v;
        logic               s;
    } clip_t;

    // Limiter setup: either a quotient to form or a direct value
    typedef struct packed {
        logic signed [DW-1:0] num;
        logic signed [DW-1:0] den;
        logic signed [31:0]   pd;
        logic                 pdiv;
    } pre_t;

    // One divider stage
    typedef struct packed {
        logic [NW-1:0] nf;
        logic [MW-1:0] b;
        logic [MW-1:0] rem;
        logic [QB-1:0] q;
        logic          ovf;
        logic          neg;
        logic          nneg;
        logic          nz;
        logic          dz;
    } div_st_t;

    // Per-item context carried down the pipeline
    typedef struct packed {
        logic signed [31:0]   l;
        logic signed [31:0]   r;
        logic signed [32:0]   dl;
        logic signed [32:0]   dr;
        logic signed [32:0]   drr;
        logic                 bnd;
        logic signed [31:0]   rl;
        logic signed [31:0]   rrt;
        logic signed [31:0]   rinv;
        logic signed [31:0]   phi_l;
        logic signed [31:0]   phi_r;
        logic signed [31:0]   rp;
        logic signed [31:0]   left;
        logic signed [31:0]   right;
        logic                 sat_l;
        logic                 sat_r;
        logic [63:0]          sqp;
        logic [64:0]          prod;
        logic signed [DW-1:0] num;
        logic signed [DW-1:0] den;
        logic signed [31:0]   pd;
        logic                 pdiv;
    } ctx_t;

    // Result beat
    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic               sat;
    } res_t;

    function automatic clip_t clip32(input logic signed [CW-1:0] x);
        clip_t c;
        if (x > CLIP_HI) begin
            c.v = 32'sh7fffffff;
            c.s = 1'b1;
        end else if (x < CLIP_LO) begin
            c.v = 32'sh80000000;
            c.s = 1'b1;
        end else begin
            c.v = x[31:0];
            c.s = 1'b0;
        end
        return c;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] x);
        return x[32] ? 33'(-x) : 33'(x);
    endfunction

    function automatic logic [63:0] umul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p;
    endfunction

    function automatic logic [64:0] umul33(input logic [31:0] a, input logic [32:0] b);
        logic [64:0] p;
        p = {33'd0, a} * {32'd0, b};
        return p;
    endfunction

    // Signed value from a magnitude and a sign
    function automatic logic signed [CW-1:0] apply_sign(input logic [64:0] m,
                                                        input logic neg);
        logic signed [CW-1:0] t;
        t = $signed({{(CW-65){1'b0}}, m});
        return neg ? -t : t;
    endfunction

    // Limiter front end: quotient operands or a direct value
    function automatic pre_t phi_pre(input lim_e sel, input logic signed [31:0] r,
                                     input logic [MW-1:0] sq);
        pre_t                 p;
        logic signed [DW-1:0] rw;
        logic signed [DW-1:0] sw;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        logic signed [DW-1:0] m;
        rw = DW'(r);
        sw = $signed({1'b0, sq});
        p.num  = '0;
        p.den  = '0;
        p.pd   = '0;
        p.pdiv = 1'b0;
        a = '0;
        b = '0;
        m = '0;
        unique case (sel)
            LIM_KOREN: begin
                if (!r[31]) begin
                    p.num  = 2 * sw + rw;
                    p.den  = 2 * sw - rw + 2 * ONE_W;
                    p.pdiv = 1'b1;
                end
            end
            LIM_ALBADA: begin
                p.num  = sw + rw;
                p.den  = sw + ONE_W;
                p.pdiv = 1'b1;
            end
            LIM_SUPERBEE: begin
                a = (2 * rw < ONE_W) ? 2 * rw : ONE_W;
                b = (rw < 2 * ONE_W) ? rw : 2 * ONE_W;
                m = (a > b) ? a : b;
                p.pd = (m > 0) ? m[31:0] : 32'sd0;
            end
            LIM_MINMOD: begin
                if (rw <= 0) p.pd = 32'sd0;
                else if (rw > ONE_W) p.pd = ONE_W[31:0];
                else p.pd = r;
            end
            LIM_VANLEER: begin
                if (!r[31]) begin
                    p.num  = 2 * rw;
                    p.den  = ONE_W + rw;
                    p.pdiv = 1'b1;
                end
            end
            LIM_CUSTOM: begin
                if (!r[31]) begin
                    if (rw < ONE_W) begin
                        p.pd = r;
                    end else begin
                        p.num  = 2 * sw;
                        p.den  = sw + ONE_W;
                        p.pdiv = 1'b1;
                    end
                end
            end
            default: begin
                p.pd = 32'sd0;
            end
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/muscl_limited_face_reconstruction.sv */
`timescale 1ns / 1ps
// MUSCL limited face reconstruction, signed Q16.16, fully pipelined.
// The three serial divider chains make up most of the pipeline depth. Throughput:
// one face per cycle while the output skid stage is not full.
// Reset (aresetn low, synchronous) empties the pipeline and selects first order.
// Uses mlfr_pkg, mlfr_div, mlfr_dly, mlfr_skid.
module muscl_limited_face_reconstruction (
    input  logic         aclk,
    input  logic         aresetn,
    // config
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_data,   // limiter_select
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,    // cell_far_left, cell_left, cell_right, cell_far_right
    input  logic         s_tuser,    // is_boundary
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,    // left_state, right_state
    output logic         m_tuser     // saturated
);
    import mlfr_pkg::*;

    lim_e            sel_reg;
    ctx_t            stg_reg  [NSTG];
    ctx_t            stg_next [NSTG];
    logic [NSTG-1:0] vld_reg, vld_next;
    logic            en;

    logic signed [DW-1:0] d1a_n, d1a_d, d1b_n, d1b_d;
    logic signed [DW-1:0] d2a_n, d2a_d, d2b_n, d2b_d;
    logic signed [DW-1:0] d3_n, d3_d;
    logic signed [31:0]   q1a, q1b, q2a, q2b, q3;
    logic                 s1a, s1b, s2a, s2b, s3;
    logic                 v1, v2, v3;
    ctx_t                 c1, c2, c3;
    res_t                 res, m_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = en;

    // Divider operands
    assign d1a_n = DW'(stg_reg[0].dr);
    assign d1a_d = DW'(stg_reg[0].dl) + EPS_W;
    assign d1b_n = DW'(stg_reg[0].drr);
    assign d1b_d = DW'(stg_reg[0].dr) + EPS_W;
    assign d2a_n = stg_reg[3].num;
    assign d2a_d = stg_reg[3].den;
    assign d2b_n = ONE_W;
    assign d2b_d = DW'(stg_reg[3].rrt);
    assign d3_n  = stg_reg[6].num;
    assign d3_d  = stg_reg[6].den;

    // Smoothness ratios
    mlfr_div u_div1a (.aclk, .en, .num(d1a_n), .den(d1a_d), .quo(q1a), .sat(s1a));
    mlfr_div u_div1b (.aclk, .en, .num(d1b_n), .den(d1b_d), .quo(q1b), .sat(s1b));
    mlfr_dly u_dly1 (.aclk, .aresetn, .en, .in_valid(vld_reg[0]), .in_ctx(stg_reg[0]),
                     .out_valid(v1), .out_ctx(c1));

    // Left limiter quotient and 1/rR
    mlfr_div u_div2a (.aclk, .en, .num(d2a_n), .den(d2a_d), .quo(q2a), .sat(s2a));
    mlfr_div u_div2b (.aclk, .en, .num(d2b_n), .den(d2b_d), .quo(q2b), .sat(s2b));
    mlfr_dly u_dly2 (.aclk, .aresetn, .en, .in_valid(vld_reg[3]), .in_ctx(stg_reg[3]),
                     .out_valid(v2), .out_ctx(c2));

    // Right limiter quotient
    mlfr_div u_div3 (.aclk, .en, .num(d3_n), .den(d3_d), .quo(q3), .sat(s3));
    mlfr_dly u_dly3 (.aclk, .aresetn, .en, .in_valid(vld_reg[6]), .in_ctx(stg_reg[6]),
                     .out_valid(v3), .out_ctx(c3));

    // Stage logic
    always_comb begin
        ctx_t               c;
        clip_t              ca;
        clip_t              cb;
        pre_t               p;
        logic signed [31:0] ll, l, r, rr;
        ll = s_tdata[31:0];
        l  = s_tdata[63:32];
        r  = s_tdata[95:64];
        rr = s_tdata[127:96];

        // S0: differences
        c     = '0;
        c.l   = l;
        c.r   = r;
        c.bnd = s_tuser;
        c.dl  = 33'(l) - 33'(ll);
        c.dr  = 33'(r) - 33'(l);
        c.drr = 33'(rr) - 33'(r);
        stg_next[0] = c;

        // S1: ratios plus epsilon
        c  = c1;
        ca = clip32(CW'(q1a) + EPS_C);
        cb = clip32(CW'(q1b) + EPS_C);
        c.rl    = ca.v;
        c.sat_l = s1a | ca.s;
        c.rrt   = cb.v;
        c.sat_r = s1b | cb.s;
        stg_next[1] = c;

        // S2: square of rL
        c     = stg_reg[1];
        c.sqp = umul32(mag32(c.rl), mag32(c.rl));
        stg_next[2] = c;

        // S3: left limiter setup
        c      = stg_reg[2];
        p      = phi_pre(sel_reg, c.rl, c.sqp[63:FRAC_BITS]);
        c.num  = p.num;
        c.den  = p.den;
        c.pd   = p.pd;
        c.pdiv = p.pdiv;
        stg_next[3] = c;

        // S4: left phi, 1/rR
        c       = c2;
        c.phi_l = c.pdiv ? q2a : c.pd;
        c.sat_l = c.sat_l | (c.pdiv & s2a);
        c.rinv  = q2b;
        c.sat_r = c.sat_r | s2b;
        stg_next[4] = c;

        // S5: square of 1/rR, left slope product
        c      = stg_reg[4];
        c.sqp  = umul32(mag32(c.rinv), mag32(c.rinv));
        c.prod = umul33(mag32(c.phi_l), mag33(c.dl));
        stg_next[5] = c;

        // S6: left state, right limiter setup
        c       = stg_reg[5];
        ca      = clip32(CW'(c.l) + apply_sign(c.prod >> (FRAC_BITS + 1),
                                               c.phi_l[31] ^ c.dl[32]));
        c.left  = ca.v;
        c.sat_l = c.sat_l | ca.s;
        p       = phi_pre(sel_reg, c.rinv, c.sqp[63:FRAC_BITS]);
        c.num   = p.num;
        c.den   = p.den;
        c.pd    = p.pd;
        c.pdiv  = p.pdiv;
        stg_next[6] = c;

        // S7: right phi
        c       = c3;
        c.phi_r = c.pdiv ? q3 : c.pd;
        c.sat_r = c.sat_r | (c.pdiv & s3);
        stg_next[7] = c;

        // S8: rR * phi
        c      = stg_reg[7];
        c.prod = {1'b0, umul32(mag32(c.rrt), mag32(c.phi_r))};
        stg_next[8] = c;

        // S9: scaled and clipped
        c       = stg_reg[8];
        ca      = clip32(apply_sign(c.prod >> FRAC_BITS, c.rrt[31] ^ c.phi_r[31]));
        c.rp    = ca.v;
        c.sat_r = c.sat_r | ca.s;
        stg_next[9] = c;

        // S10: right slope product
        c      = stg_reg[9];
        c.prod = umul33(mag32(c.rp), mag33(c.dr));
        stg_next[10] = c;

        // S11: right state
        c       = stg_reg[10];
        ca      = clip32(CW'(c.r) - apply_sign(c.prod >> (FRAC_BITS + 1),
                                               c.rp[31] ^ c.dr[32]));
        c.right = ca.v;
        c.sat_r = c.sat_r | ca.s;
        stg_next[11] = c;

        // Valid bits
        vld_next[0]  = s_tvalid;
        vld_next[1]  = v1;
        vld_next[2]  = vld_reg[1];
        vld_next[3]  = vld_reg[2];
        vld_next[4]  = v2;
        vld_next[5]  = vld_reg[4];
        vld_next[6]  = vld_reg[5];
        vld_next[7]  = v3;
        vld_next[8]  = vld_reg[7];
        vld_next[9]  = vld_reg[8];
        vld_next[10] = vld_reg[9];
        vld_next[11] = vld_reg[10];
    end

    // Result select: first order, boundary pass-through, limited
    always_comb begin
        if (sel_reg == LIM_FIRST || sel_reg > LIM_CUSTOM) begin
            res.left  = stg_reg[11].l;
            res.right = stg_reg[11].r;
            res.sat   = 1'b0;
        end else begin
            res.left  = stg_reg[11].left;
            res.right = stg_reg[11].bnd ? stg_reg[11].r : stg_reg[11].right;
            res.sat   = stg_reg[11].sat_l | (~stg_reg[11].bnd & stg_reg[11].sat_r);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= LIM_FIRST;
            vld_reg <= '0;
        end else begin
            if (cfg_valid) sel_reg <= lim_e'(cfg_data);
            if (en) vld_reg <= vld_next;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg <= stg_next;
        end
    end

    mlfr_skid u_skid (
        .aclk, .aresetn,
        .p_valid (vld_reg[NSTG-1]),
        .p_data  (res),
        .en      (en),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_res   (m_res)
    );

    assign m_tdata = {m_res.right, m_res.left};
    assign m_tuser = m_res.sat;

endmodule

/* rtl/core/mlfr_div.sv */
`timescale 1ns / 1ps
// Pipelined signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero and clipped to 32 bits, one quotient bit per stage. Uses mlfr_pkg.
module mlfr_div (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [mlfr_pkg::DW-1:0] num,
    input  logic signed [mlfr_pkg::DW-1:0] den,
    output logic signed [31:0]             quo,
    output logic                           sat
);
    import mlfr_pkg::*;

    div_st_t            st_reg  [QB+2];
    div_st_t            st_next [QB+2];
    logic [MW:0]        rs_w    [QB];
    logic signed [31:0] quo_reg, quo_next;
    logic               sat_reg, sat_next;

    // Stage logic: entry, first partial remainder, then one bit per stage
    always_comb begin
        logic [DW-1:0] mn;
        logic [DW-1:0] md;
        logic [MW-1:0] r0;
        div_st_t       f;
        logic          cap;
        mn = num[DW-1] ? DW'(-num) : DW'(num);
        md = den[DW-1] ? DW'(-den) : DW'(den);
        st_next[0].nf   = {mn[MW-1:0], {FRAC_BITS{1'b0}}};
        st_next[0].b    = md[MW-1:0];
        st_next[0].rem  = '0;
        st_next[0].q    = '0;
        st_next[0].ovf  = 1'b0;
        st_next[0].neg  = num[DW-1] ^ den[DW-1];
        st_next[0].nneg = num[DW-1];
        st_next[0].nz   = (num != '0);
        st_next[0].dz   = (den == '0);

        r0 = {{(MW-(NW-QB)){1'b0}}, st_reg[0].nf[NW-1:QB]};
        st_next[1]     = st_reg[0];
        st_next[1].rem = r0;
        st_next[1].ovf = (r0 >= st_reg[0].b);

        for (int j = 0; j < QB; j++) begin
            st_next[j+2] = st_reg[j+1];
            rs_w[j] = {st_reg[j+1].rem, st_reg[j+1].nf[QB-1-j]};
            if (rs_w[j] >= {1'b0, st_reg[j+1].b}) begin
                st_next[j+2].rem      = MW'(rs_w[j] - {1'b0, st_reg[j+1].b});
                st_next[j+2].q[QB-1-j] = 1'b1;
            end else begin
                st_next[j+2].rem = rs_w[j][MW-1:0];
            end
        end

        // Sign, zero cases and clipping
        f   = st_reg[QB+1];
        cap = f.ovf | f.q[QB-1];
        if (!f.nz) begin
            quo_next = '0;
            sat_next = 1'b0;
        end else if (f.dz) begin
            quo_next = f.nneg ? 32'sh80000000 : 32'sh7fffffff;
            sat_next = 1'b1;
        end else if (!f.neg) begin
            if (cap | f.q[31]) begin
                quo_next = 32'sh7fffffff;
                sat_next = 1'b1;
            end else begin
                quo_next = $signed(f.q[31:0]);
                sat_next = 1'b0;
            end
        end else begin
            if (cap | (f.q[31] & (|f.q[30:0]))) begin
                quo_next = 32'sh80000000;
                sat_next = 1'b1;
            end else begin
                quo_next = $signed(32'(-f.q[31:0]));
                sat_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg  <= st_next;
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

/* rtl/core/mlfr_dly.sv */
`timescale 1ns / 1ps
// Context delay line matching the divider latency; carries the valid bit.
// Uses mlfr_pkg.
module mlfr_dly (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  mlfr_pkg::ctx_t in_ctx,
    output logic           out_valid,
    output mlfr_pkg::ctx_t out_ctx
);
    import mlfr_pkg::*;

    ctx_t               ctx_reg [DIV_LAT];
    logic [DIV_LAT-1:0] vld_reg;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], in_valid};
        end
    end

    // Context shift
    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= in_ctx;
            for (int k = 1; k < DIV_LAT; k++) begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[DIV_LAT-1];
    assign out_ctx   = ctx_reg[DIV_LAT-1];

endmodule

/* rtl/core/mlfr_skid.sv */
`timescale 1ns / 1ps
// Output register plus skid stage; stalls the pipeline only when both are full.
// Uses mlfr_pkg.
module mlfr_skid (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           p_valid,
    input  mlfr_pkg::res_t p_data,
    output logic           en,
    input  logic           m_tready,
    output logic           m_tvalid,
    output mlfr_pkg::res_t m_res
);
    import mlfr_pkg::*;

    res_t out_reg, skid_reg;
    logic out_vld_reg, skid_vld_reg;
    logic take;

    assign take = out_vld_reg & m_tready;
    assign en   = ~skid_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            // drain skid beat into the output register
            if (take) begin
                out_reg      <= skid_reg;
                skid_vld_reg <= 1'b0;
            end
        end else if (p_valid) begin
            if (!out_vld_reg || take) begin
                out_reg     <= p_data;
                out_vld_reg <= 1'b1;
            end else begin
                skid_reg     <= p_data;
                skid_vld_reg <= 1'b1;
            end
        end else if (take) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_res    = out_reg;

endmodule
